@@ design/ps2mct_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared constants and types for the PS/2 mouse packet cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LimW  = 12;
  localparam int unsigned CurW  = 12;
  localparam int unsigned DxW   = 9;
  localparam int unsigned DyW   = 10;
  localparam int unsigned BtnW  = 3;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned OutDataW = 48;

  localparam logic [ByteW-1:0] AckByte  = 8'hFA;
  localparam logic [ByteW-1:0] HdrMask  = 8'hC8;
  localparam logic [ByteW-1:0] HdrValue = 8'h08;

  localparam logic [LimW-1:0] LimitXReset = 12'd304;
  localparam logic [LimW-1:0] LimitYReset = 12'd184;

  localparam logic [CfgIdxW-1:0] CfgLimitX = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgLimitY = 4'd1;

  // slot of the next byte within a packet
  localparam logic [1:0] SlotHdr = 2'd0;
  localparam logic [1:0] SlotX   = 2'd1;
  localparam logic [1:0] SlotY   = 2'd2;

  typedef struct packed {
    logic [CurW-1:0]       cursor_y;
    logic [CurW-1:0]       cursor_x;
    logic signed [DyW-1:0] delta_y;
    logic signed [DxW-1:0] delta_x;
    logic [BtnW-1:0]       buttons;
  } result_t;

endpackage

@@ design/ps2_mouse_packet_cursor_tracker.sv @@
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker
// Decodes three-byte PS/2 mouse packets and tracks a clamped cursor position.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  s_axis   | in  | rx_byte, one beat per byte from the mouse
//  m_axis   | out | buttons, delta_x, delta_y, cursor_x, cursor_y per packet
//  cfg      | in  | register index and value (cursor_limit_x, cursor_limit_y)
//
//  One beat per cycle in while s_axis_tready is high; each byte is decoded in the
//  cycle it is taken; a finished packet lands in the output register on the next edge.
//  The output register is the only stage: s_axis_tready drops only while a
//  result waits and m_axis_tready is low.
//  After reset all bytes are dropped until the 0xFA acknowledge; cursor at 100,100.
//  Config writes are taken every cycle (cfg_ready_o tied high).
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker #(
  parameter int unsigned POS_BITS = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ps2mct_pkg::ByteW-1:0]     s_axis_tdata,  // [7:0] rx_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [2:0] buttons, [11:3] delta_x, [21:12] delta_y, [33:22] cursor_x,
  // [45:34] cursor_y, [47:46] zero
  output logic [ps2mct_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ps2mct_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ps2mct_pkg::LimW-1:0]      cfg_data_i
);
  import ps2mct_pkg::*;

  localparam int unsigned SumW = ((POS_BITS > LimW) ? POS_BITS : LimW) + 2;
  localparam logic [POS_BITS-1:0] PosReset = POS_BITS'(100);

  logic [LimW-1:0]     limit_x_q, limit_y_q;
  logic                await_ack_q, await_ack_d;
  logic [1:0]          slot_q, slot_d;
  logic [ByteW-1:0]    hdr_q, xbyte_q;
  logic [POS_BITS-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic                out_valid_q, out_valid_d;
  result_t             res_q, res_d;

  logic                in_fire, pkt_done, hdr_ok;
  logic [DxW-1:0]      dx;
  logic [DxW-1:0]      dy_raw;
  logic [DyW-1:0]      dy;

  function automatic logic [POS_BITS-1:0] move_axis(
    input logic [POS_BITS-1:0] pos,
    input logic [DyW-1:0]      delta,
    input logic [LimW-1:0]     limit
  );
    logic signed [SumW-1:0] sum;
    logic signed [SumW-1:0] lim_w;
    logic signed [SumW-1:0] mask_w;
    logic signed [SumW-1:0] top;
    logic signed [SumW-1:0] res;
    lim_w  = $signed({{(SumW-LimW){1'b0}}, limit});
    mask_w = $signed({{(SumW-POS_BITS){1'b0}}, {POS_BITS{1'b1}}});
    top    = (lim_w < mask_w) ? lim_w : mask_w;
    sum    = $signed({{(SumW-POS_BITS){1'b0}}, pos})
           + $signed({{(SumW-DyW){delta[DyW-1]}}, delta});
    if (sum < 0) begin
      res = '0;
    end else if (sum > top) begin
      res = top;
    end else begin
      res = sum;
    end
    return res[POS_BITS-1:0];
  endfunction

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign hdr_ok = (s_axis_tdata & HdrMask) == HdrValue;
  assign dx     = {hdr_q[4], xbyte_q};
  assign dy_raw = {hdr_q[5], s_axis_tdata};
  // negate after widening so +256 fits
  assign dy     = DyW'(0) - {dy_raw[DxW-1], dy_raw};

  always_comb begin
    await_ack_d = await_ack_q;
    slot_d      = slot_q;
    pkt_done    = 1'b0;
    if (in_fire) begin
      if (await_ack_q) begin
        if (s_axis_tdata == AckByte) begin
          await_ack_d = 1'b0;
          slot_d      = SlotHdr;
        end
      end else begin
        unique case (slot_q)
          SlotHdr: if (hdr_ok) slot_d = SlotX;
          SlotX:   slot_d = SlotY;
          SlotY: begin
            slot_d   = SlotHdr;
            pkt_done = 1'b1;
          end
          default: slot_d = SlotHdr;
        endcase
      end
    end
  end

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    if (pkt_done) begin
      pos_x_d = move_axis(pos_x_q, {dx[DxW-1], dx}, limit_x_q);
      pos_y_d = move_axis(pos_y_q, dy, limit_y_q);
    end
  end

  always_comb begin
    res_d          = res_q;
    res_d.buttons  = hdr_q[BtnW-1:0];
    res_d.delta_x  = $signed(dx);
    res_d.delta_y  = $signed(dy);
    res_d.cursor_x = CurW'(pos_x_d);
    res_d.cursor_y = CurW'(pos_y_d);
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (pkt_done) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      await_ack_q <= 1'b1;
      slot_q      <= SlotHdr;
      pos_x_q     <= PosReset;
      pos_y_q     <= PosReset;
      out_valid_q <= 1'b0;
      limit_x_q   <= LimitXReset;
      limit_y_q   <= LimitYReset;
    end else begin
      await_ack_q <= await_ack_d;
      slot_q      <= slot_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_index_i == CfgLimitX) limit_x_q <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == CfgLimitY) limit_y_q <= cfg_data_i;
    end
  end

  // packet payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire && !await_ack_q && slot_q == SlotHdr && hdr_ok) hdr_q <= s_axis_tdata;
    if (in_fire && !await_ack_q && slot_q == SlotX) xbyte_q <= s_axis_tdata;
    if (pkt_done) res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, res_q};

endmodule

@@ design/ps2mct_checker.sv @@
// ----------------------------------------------------------------------------
// ps2mct_checker
// Port-level checks for the PS/2 mouse packet cursor tracker.
// ----------------------------------------------------------------------------
module ps2mct_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [ps2mct_pkg::OutDataW-1:0]  m_axis_tdata
);
  import ps2mct_pkg::*;

  // a held result blocks the input side
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result stalled");

  // a new result only follows an accepted byte
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid && !(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
    else $error("result without input beat");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("m_axis_tvalid dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("m_axis_tdata changed while stalled");

endmodule

bind ps2_mouse_packet_cursor_tracker ps2mct_checker u_ps2mct_checker (.*);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PS/2 mouse packet cursor tracker: a directed
// table (acknowledge wait, bad headers, sign and clamp extremes, limit
// changes), then random well-formed packets mixed with stray bytes under
// several cursor limits. A bench decoder predicts all beats but golden rows.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2mct_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int IdlePct       = 29;
  localparam int PhaseBytes    = 68;
  localparam int HoldCycles    = 120;
  localparam int MaxPrints     = 50;
  localparam logic [CfgIdxW-1:0] CfgIdxTop = '1;

  typedef enum logic {RowByte, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [LimW-1:0]     val;
    logic [ByteW-1:0]    rx;
    logic                typed;
    result_t             golden;
  } dir_row_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [ByteW-1:0]    s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [LimW-1:0]     cfg_data_i    = '0;

  ps2_mouse_packet_cursor_tracker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // decoder state, mirrors the block
  bit              waiting_ack = 1'b1;
  logic [1:0]      slot        = SlotHdr;
  logic [ByteW-1:0] hdr        = '0;
  logic [ByteW-1:0] xbyte      = '0;
  logic [CurW-1:0] cur_x       = 12'd100;
  logic [CurW-1:0] cur_y       = 12'd100;
  logic [LimW-1:0] lim_x       = LimitXReset;
  logic [LimW-1:0] lim_y       = LimitYReset;

  result_t  expected_packets[$];
  dir_row_t dir_rows[$];
  int n_err       = 0;
  int n_in        = 0;
  int n_out       = 0;
  int quiet_count = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [CurW-1:0] clamp_axis(logic [CurW-1:0] pos, int delta,
                                                  logic [LimW-1:0] lim);
    int v;
    // position range equals limit range here, so the limit is the ceiling
    v = int'(pos) + delta;
    if (v < 0) v = 0;
    if (v > int'(lim)) v = int'(lim);
    return v[CurW-1:0];
  endfunction

  task automatic decode_byte(input logic [ByteW-1:0] b, output bit emitted,
                             output result_t res);
    int dx;
    int dy;
    emitted = 1'b0;
    res     = '0;
    if (waiting_ack) begin
      if (b == AckByte) begin
        waiting_ack = 1'b0;
        slot        = SlotHdr;
      end
    end else begin
      case (slot)
        SlotHdr: begin
          if ((b & HdrMask) == HdrValue) begin
            hdr  = b;
            slot = SlotX;
          end
        end
        SlotX: begin
          xbyte = b;
          slot  = SlotY;
        end
        default: begin
          slot = SlotHdr;
          dx = hdr[4] ? int'(xbyte) - 256 : int'(xbyte);
          dy = hdr[5] ? int'(b) - 256 : int'(b);
          dy = -dy;
          cur_x = clamp_axis(cur_x, dx, lim_x);
          cur_y = clamp_axis(cur_y, dy, lim_y);
          res.buttons  = hdr[BtnW-1:0];
          res.delta_x  = dx[DxW-1:0];
          res.delta_y  = dy[DyW-1:0];
          res.cursor_x = cur_x;
          res.cursor_y = cur_y;
          emitted = 1'b1;
        end
      endcase
    end
  endtask

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [LimW-1:0] val);
    if (idx == CfgLimitX) lim_x = val;
    else if (idx == CfgLimitY) lim_y = val;
  endfunction

  function automatic result_t mk_res(logic [BtnW-1:0] btn, logic [DxW-1:0] dx,
                                     logic [DyW-1:0] dy, logic [CurW-1:0] cx,
                                     logic [CurW-1:0] cy);
    result_t r;
    r.buttons  = btn;
    r.delta_x  = dx;
    r.delta_y  = dy;
    r.cursor_x = cx;
    r.cursor_y = cy;
    return r;
  endfunction

  function automatic dir_row_t row_byte(logic [ByteW-1:0] rx);
    dir_row_t r;
    r      = '0;
    r.kind = RowByte;
    r.rx   = rx;
    return r;
  endfunction

  function automatic dir_row_t row_pkt(logic [ByteW-1:0] rx, result_t golden);
    dir_row_t r;
    r        = row_byte(rx);
    r.typed  = 1'b1;
    r.golden = golden;
    return r;
  endfunction

  function automatic dir_row_t row_cfg(logic [CfgIdxW-1:0] idx, logic [LimW-1:0] val);
    dir_row_t r;
    r      = '0;
    r.kind = RowCfg;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    n_err++;
    if (n_err <= MaxPrints)
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  task automatic check_packet(input logic [OutDataW-1:0] beat);
    result_t got;
    result_t want;
    got = result_t'(beat[$bits(result_t)-1:0]);
    if (expected_packets.size() == 0) begin
      report_mismatch("unexpected result beat", int'(got.cursor_x), -1);
      return;
    end
    want = expected_packets.pop_front();
    if (got.buttons != want.buttons)
      report_mismatch("buttons", int'(got.buttons), int'(want.buttons));
    if (got.delta_x != want.delta_x)
      report_mismatch("delta_x", int'(got.delta_x), int'(want.delta_x));
    if (got.delta_y != want.delta_y)
      report_mismatch("delta_y", int'(got.delta_y), int'(want.delta_y));
    if (got.cursor_x != want.cursor_x)
      report_mismatch("cursor_x", int'(got.cursor_x), int'(want.cursor_x));
    if (got.cursor_y != want.cursor_y)
      report_mismatch("cursor_y", int'(got.cursor_y), int'(want.cursor_y));
    if (beat[OutDataW-1:$bits(result_t)] != '0)
      report_mismatch("pad bits", int'(beat[OutDataW-1:$bits(result_t)]), 0);
  endtask

  // Offers one byte; valid stays high after the beat so back-to-back bytes
  // never lower and raise it in one step.
  task automatic push_byte(input logic [ByteW-1:0] b, input bit typed = 1'b0,
                           input result_t golden = '0);
    bit      emitted;
    result_t res;
    if (!(n_in >= 200 && n_in < 330)) begin
      // each idle cycle drawn on its own
      while ($urandom_range(99) < IdlePct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_in++;
    decode_byte(b, emitted, res);
    if (emitted) expected_packets.push_back(typed ? golden : res);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [LimW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, val);
  endtask

  // stop offering, wait out all pending results plus pipeline slack
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_packets.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // result side: check accepted beats, random stalls, a stall-free window, one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_packet(m_axis_tdata);
      n_out++;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && n_in >= 450) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (n_out >= 60 && n_out < 110) || ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_count <= 0;
    end else if (quiet_count >= WatchdogLimit) begin
      $display("ps2_mouse_packet_cursor_tracker regression: fail");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin
    int lim_plan_x[10];
    int lim_plan_y[10];
    int sent;
    bit cfg_open;
    logic [LimW-1:0] lx;
    logic [LimW-1:0] ly;

    lim_plan_x = '{0, 4095, 1, 4095, -1, -1, 0, -1, -1, 304};
    lim_plan_y = '{0, 4095, 4095, 0, -1, -1, 4095, -1, -1, 184};
    cfg_open = 1'b0;

    dir_rows = '{
      row_byte(8'h08),                                     // dropped, no ack yet
      row_byte(8'hFF),
      row_byte(AckByte),
      row_byte(8'hC8),                                     // bad headers
      row_byte(8'h00),
      row_byte(8'h0F), row_byte(8'h00),
      row_pkt(8'h00, mk_res(3'd7, 9'd0, 10'd0, 12'd100, 12'd100)),
      row_byte(8'h38), row_byte(8'h00),                    // dx -256, dy +255
      row_pkt(8'h01, mk_res(3'd0, 9'h100, 10'd255, 12'd0, 12'd184)),
      row_byte(8'h08), row_byte(8'hFF),                    // dx +255, dy -255
      row_pkt(8'hFF, mk_res(3'd0, 9'd255, 10'h301, 12'd255, 12'd0)),
      row_byte(8'h28), row_byte(8'hFF),                    // dy +256, both clamp high
      row_pkt(8'h00, mk_res(3'd0, 9'd255, 10'd256, 12'd304, 12'd184)),
      row_byte(AckByte),                                   // fails header test after ack
      row_byte(8'h09), row_byte(8'hC8), row_byte(AckByte), // slots 1 and 2 unchecked
      row_cfg(CfgLimitX, 12'd4095), row_cfg(CfgLimitY, 12'd4095),
      row_byte(8'h28), row_byte(8'hFF), row_byte(8'h01),
      // limits drop below the cursor: the next still packet pulls it in
      row_cfg(CfgLimitX, 12'd200), row_cfg(CfgLimitY, 12'd100),
      row_byte(8'h0C), row_byte(8'h00),
      row_pkt(8'h00, mk_res(3'd4, 9'd0, 10'd0, 12'd200, 12'd100))
    };

    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowCfg) begin
        if (!cfg_open) begin
          settle();
          cfg_open = 1'b1;
        end
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        if (cfg_open) begin
          cfg_valid_i <= 1'b0;
          cfg_open = 1'b0;
        end
        push_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].golden);
      end
    end

    for (int p = 0; p < 10; p++) begin
      settle();
      lx = (lim_plan_x[p] < 0) ? LimW'($urandom_range(0, 4095)) : LimW'(lim_plan_x[p]);
      ly = (lim_plan_y[p] < 0) ? LimW'($urandom_range(0, 4095)) : LimW'(lim_plan_y[p]);
      // unused index, must leave both limits alone
      if ($urandom_range(2) == 0)
        write_reg(CfgIdxW'($urandom_range(int'(CfgLimitY) + 1, int'(CfgIdxTop))),
                  LimW'($urandom_range(0, 4095)));
      if ($urandom_range(1) == 0) begin
        write_reg(CfgLimitX, lx);
        write_reg(CfgLimitY, ly);
      end else begin
        write_reg(CfgLimitY, ly);
        write_reg(CfgLimitX, lx);
      end
      cfg_valid_i <= 1'b0;

      sent = 0;
      while (sent < PhaseBytes) begin
        if ($urandom_range(99) < 85) begin
          // header: bits 7..6 clear, bit 3 set, signs and buttons random
          push_byte({2'b00, 2'($urandom_range(0, 3)), 1'b1, 3'($urandom_range(0, 7))});
          push_byte(ByteW'($urandom_range(0, 255)));
          push_byte(ByteW'($urandom_range(0, 255)));
          sent += 3;
        end else begin
          push_byte(ByteW'($urandom_range(0, 255)));
          sent++;
        end
      end
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (n_err == 0) begin
      $display("ps2_mouse_packet_cursor_tracker regression: pass");
    end else begin
      $display("ps2_mouse_packet_cursor_tracker regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ps2mct_pkg.sv
design/ps2_mouse_packet_cursor_tracker.sv
design/ps2mct_checker.sv
tb/testbench.sv
